/* src/stq_pkg.sv */
// Sorted timer queue: shared types, constants and helper functions.
// Used by stq_ctrl, stq_datapath and sorted_timer_queue_top; depends on nothing.
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int ID_W       = 4;
  localparam int TIMEOUT_W  = 31;
  localparam int DELAY_W    = 31;

  localparam logic [63:0] DELAY_MAX = 64'h0000_0000_7FFF_FFFF;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    CMD_SET    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [ID_W-1:0]      timer_id;
    logic [TIMEOUT_W-1:0] timeout;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    expired_id;
    logic [DELAY_W-1:0] next_delay;
    logic               queue_empty;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REMOVE,
    ST_INS_START,
    ST_INSERT,
    ST_TICK,
    ST_EXPIRE,
    ST_STATUS
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic remove_id;
    logic remove_head;
    logic ins_start;
    logic ins_step;
    logic tick;
    logic load_expiry;
    logic load_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       id_ok;
    logic       full;
    logic       head_due;
    logic       ins_move;
    logic       out_free;
  } dp_status_t;

  // a strictly before b, wrap-aware
  function automatic logic is_before(time_t a, time_t b);
    time_t d;
    d = b - a;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

endpackage

/* src/stq_ctrl.sv */
// Sorted timer queue: controller state machine.
// Depends on stq_pkg; drives stq_datapath through dp_cmd_t and reads dp_status_t.
module stq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stq_pkg::dp_status_t st,
  output stq_pkg::dp_cmd_t    cmd
);

  stq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = stq_pkg::ST_DISPATCH;
      end
      stq_pkg::ST_DISPATCH: begin
        unique case (st.cmd) inside
          stq_pkg::CMD_SET, stq_pkg::CMD_CANCEL: begin
            state_nxt = st.id_ok ? stq_pkg::ST_REMOVE : stq_pkg::ST_STATUS;
          end
          stq_pkg::CMD_TICK: state_nxt = stq_pkg::ST_TICK;
          default:           state_nxt = stq_pkg::ST_STATUS;
        endcase
      end
      stq_pkg::ST_REMOVE: begin
        state_nxt = (st.cmd == stq_pkg::CMD_SET) ? stq_pkg::ST_INS_START : stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_INS_START: begin
        state_nxt = st.full ? stq_pkg::ST_STATUS : stq_pkg::ST_INSERT;
      end
      stq_pkg::ST_INSERT: begin
        if (!st.ins_move) state_nxt = stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_TICK: state_nxt = stq_pkg::ST_EXPIRE;
      stq_pkg::ST_EXPIRE: begin
        if (!st.head_due) state_nxt = stq_pkg::ST_STATUS;
      end
      stq_pkg::ST_STATUS: begin
        if (st.out_free) state_nxt = stq_pkg::ST_IDLE;
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      stq_pkg::ST_REMOVE:    cmd.remove_id = 1'b1;
      stq_pkg::ST_INS_START: cmd.ins_start = 1'b1;
      stq_pkg::ST_INSERT:    cmd.ins_step  = 1'b1;
      stq_pkg::ST_TICK:      cmd.tick      = 1'b1;
      stq_pkg::ST_EXPIRE: begin
        // pop one due head per cycle, only when the output register can take it
        if (st.head_due && st.out_free) begin
          cmd.load_expiry = 1'b1;
          cmd.remove_head = 1'b1;
        end
      end
      stq_pkg::ST_STATUS:    cmd.load_status = st.out_free;
      default: ;
    endcase
  end

  // the expiry state waits on out_free by staying put while head_due holds
endmodule

/* src/stq_datapath.sv */
// Sorted timer queue: time counter, sorted slot cells, insert walker and output register.
// Depends on stq_pkg; controlled by stq_ctrl.
module stq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::in_item_t   in_data,
  input  stq_pkg::dp_cmd_t    cmd,
  output stq_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output stq_pkg::out_item_t  out_data
);

  logic [1:0]                   cmd_r;
  logic [stq_pkg::ID_W-1:0]     id_r;
  logic [stq_pkg::TIMEOUT_W-1:0] timeout_r;
  stq_pkg::time_t               now_r;
  logic [stq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [stq_pkg::CNT_W-1:0]    pos_r;
  stq_pkg::time_t               ins_exp_r;
  logic [stq_pkg::ID_W-1:0]     ids_r [stq_pkg::NUM_TIMERS];
  logic [stq_pkg::ID_W-1:0]     ids_nxt [stq_pkg::NUM_TIMERS];
  stq_pkg::time_t               exp_r [stq_pkg::NUM_TIMERS];
  stq_pkg::time_t               exp_nxt [stq_pkg::NUM_TIMERS];
  logic                         out_valid_r;
  stq_pkg::out_item_t           out_data_r;

  logic [stq_pkg::NUM_TIMERS-1:0] match;
  logic                           rm_any;
  logic [stq_pkg::IDX_W-1:0]      rm_idx;
  logic [stq_pkg::IDX_W-1:0]      pos_idx;
  logic [stq_pkg::IDX_W-1:0]      prev_idx;
  logic                           ins_move;
  logic                           id_ok;
  logic                           out_free;
  stq_pkg::time_t                 head_gap;
  logic [63:0]                    gap64;
  logic [stq_pkg::DELAY_W-1:0]    delay;

  assign id_ok    = (32'(id_r) < stq_pkg::NUM_TIMERS);
  assign out_free = !out_valid_r || out_ready;
  assign pos_idx  = pos_r[stq_pkg::IDX_W-1:0];
  assign prev_idx = stq_pkg::IDX_W'(pos_r - 1'b1);
  assign ins_move = (pos_r != '0) && stq_pkg::is_before(ins_exp_r, exp_r[prev_idx]);

  // locate the entry to take out: by timer id, or the head
  always_comb begin
    match = '0;
    for (int j = 0; j < stq_pkg::NUM_TIMERS; j++) begin
      if (cmd.remove_id) begin
        match[j] = (stq_pkg::CNT_W'(j) < count_r) && (ids_r[j] == id_r) && id_ok;
      end
    end
    if (cmd.remove_head) match[0] = (count_r != '0);
  end

  always_comb begin
    rm_idx = '0;
    for (int j = 0; j < stq_pkg::NUM_TIMERS; j++) begin
      if (match[j]) rm_idx = rm_idx | stq_pkg::IDX_W'(j);
    end
  end

  assign rm_any = |match;

  // slot cells: close the gap on removal, or take one insert step
  always_comb begin
    count_nxt = count_r;
    for (int j = 0; j < stq_pkg::NUM_TIMERS; j++) begin
      ids_nxt[j] = ids_r[j];
      exp_nxt[j] = exp_r[j];
    end
    if (rm_any) begin
      count_nxt = count_r - 1'b1;
      for (int j = 0; j < stq_pkg::NUM_TIMERS - 1; j++) begin
        if (stq_pkg::IDX_W'(j) >= rm_idx) begin
          ids_nxt[j] = ids_r[j+1];
          exp_nxt[j] = exp_r[j+1];
        end
      end
    end else if (cmd.ins_step) begin
      if (ins_move) begin
        ids_nxt[pos_idx] = ids_r[prev_idx];
        exp_nxt[pos_idx] = exp_r[prev_idx];
      end else begin
        ids_nxt[pos_idx] = id_r;
        exp_nxt[pos_idx] = ins_exp_r;
        count_nxt        = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < stq_pkg::NUM_TIMERS; j++) begin
      ids_r[j] <= ids_nxt[j];
      exp_r[j] <= exp_nxt[j];
    end
    if (cmd.latch_in) begin
      cmd_r     <= in_data.command;
      id_r      <= in_data.timer_id;
      timeout_r <= in_data.timeout;
    end
    if (cmd.ins_start) begin
      ins_exp_r <= now_r + stq_pkg::TIME_BITS'(timeout_r);
    end
  end

  // status delay: head expiry minus now, zero when overdue, saturated when long
  assign head_gap = exp_r[0] - now_r;
  assign gap64    = 64'(head_gap);

  always_comb begin
    if (head_gap[stq_pkg::TIME_BITS-1]) begin
      delay = '0;
    end else if (gap64 > stq_pkg::DELAY_MAX) begin
      delay = stq_pkg::DELAY_W'(stq_pkg::DELAY_MAX);
    end else begin
      delay = stq_pkg::DELAY_W'(gap64);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.tick) now_r <= now_r + 1'b1;
      if (cmd.ins_start) begin
        pos_r <= count_r;
      end else if (cmd.ins_step && ins_move) begin
        pos_r <= pos_r - 1'b1;
      end
      if (cmd.load_expiry || cmd.load_status) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_expiry) begin
      out_data_r.kind        <= stq_pkg::KIND_EXPIRY;
      out_data_r.expired_id  <= ids_r[0];
      out_data_r.next_delay  <= '0;
      out_data_r.queue_empty <= 1'b0;
      out_data_r.last        <= 1'b0;
    end else if (cmd.load_status) begin
      out_data_r.kind        <= stq_pkg::KIND_STATUS;
      out_data_r.expired_id  <= '0;
      out_data_r.next_delay  <= (count_r == '0) ? '0 : delay;
      out_data_r.queue_empty <= (count_r == '0);
      out_data_r.last        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign st.cmd      = cmd_r;
  assign st.id_ok    = id_ok;
  assign st.full     = (32'(count_r) >= stq_pkg::NUM_TIMERS);
  assign st.head_due = (count_r != '0) && !stq_pkg::is_before(now_r, exp_r[0]);
  assign st.ins_move = ins_move;
  assign st.out_free = out_free;

endmodule

/* src/sorted_timer_queue_top.sv */
// Sorted timer queue: top level joining controller and datapath.
// Depends on stq_pkg, stq_ctrl and stq_datapath.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   input   | in_valid / in_ready  | in_data   (stq_pkg::in_item_t)
//   result  | out_valid / out_ready| out_data  (stq_pkg::out_item_t)
//
// One item at a time. Set: idle, dispatch, remove, insert start, then the insert walk
// over the slot cells (one step per queued timer with a later expiry), then status. Cancel:
// idle, dispatch, remove, status. Tick: idle, dispatch, tick, expire, status. Unknown command: idle, dispatch, status.
// A stalled result port holds the controller in its expiry or status state.
// Synchronous reset empties the queue and zeroes the time counter.
module sorted_timer_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stq_pkg::out_item_t out_data
);

  stq_pkg::dp_cmd_t    cmd;
  stq_pkg::dp_status_t st;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  stq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
